// ===== src/bounded_stack_engine_assert.svh =====
// Assertion macros shared by the stack engine RTL.
`ifndef BOUNDED_STACK_ENGINE_ASSERT_SVH
`define BOUNDED_STACK_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSE_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stack engine check failed");

// Next-cycle implication, checked outside reset.
`define BSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stack engine check failed");

`endif

// ===== src/bse_pkg.sv =====
// Types and constants of the bounded stack engine.
`timescale 1ns / 1ps

package bse_pkg;

    typedef logic [2:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_CLEAR   = 3'd0;
    localparam opcode_t OP_PUSH    = 3'd1;
    localparam opcode_t OP_POP     = 3'd2;
    localparam opcode_t OP_PEEK    = 3'd3;
    localparam opcode_t OP_DUMP    = 3'd4;
    localparam opcode_t OP_REVERSE = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // A dump gives at most this many results.
    localparam int MAX_RESULTS = 32;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 5;

endpackage

// ===== src/bounded_stack_engine.sv =====
// Bounded LIFO stack engine: entry memory with one read and one write port under a small sequencer.
`timescale 1ns / 1ps

// The stack keeps DEPTH signed 32-bit words in a memory with one read port,
// one write port and a registered read, and one request is handled at a time:
// s_ready is high only while the sequencer is idle, and each result is held in
// an output register until m_ready takes it. Clear, push, reverse on fewer than
// two entries and unused opcodes go straight to the result, pop and peek wait
// for the memory read, a dump reads one entry per result, and reverse swaps
// each pair in S_REV_A, S_REV_B and S_REV_C, because every swap moves two
// words through the one read and one write port of the memory. A dump gives at
// most 32 results, the bottom 32 entries, the last one marked by m_last.
module bounded_stack_engine
    import bse_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  opcode_t                   s_opcode,
    input  logic signed [VALUE_W-1:0] s_push_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_out_value,
    output logic        [INDEX_W-1:0] m_out_index,
    output status_t                   m_status,
    output logic                      m_last
);

`include "bounded_stack_engine_assert.svh"

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int LW   = CNTW + 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DUMP,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [IDXW-1:0] lo_reg, lo_next;
    logic [IDXW-1:0] hi_reg, hi_next;
    logic [VALUE_W-1:0] tmp_reg, tmp_next;
    logic is_pop_reg, is_pop_next;

    logic m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_out_value_reg, m_out_value_next;
    logic [INDEX_W-1:0] m_out_index_reg, m_out_index_next;
    status_t m_status_reg, m_status_next;
    logic m_last_reg, m_last_next;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IDXW-1:0] rd_addr;
    logic wr_en;
    logic [IDXW-1:0] wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic [CNTW-1:0] count_m1;
    logic is_full;
    logic is_empty;
    logic dump_last;
    logic rev_more;
    logic s_fire;

    assign s_ready     = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_value = m_out_value_reg;
    assign m_out_index = m_out_index_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

    assign count_m1  = count_reg - CNTW'(1);
    assign is_full   = (count_reg == CNTW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    // The top entry, or the entry that fills the last result slot, ends a dump.
    assign dump_last = (LW'(lo_reg) + LW'(1) == LW'(count_reg))
                    || (LW'(lo_reg) == LW'(MAX_RESULTS - 1));
    // After this swap, another pair remains while lo + 1 < hi - 1.
    assign rev_more  = (LW'(lo_reg) + LW'(2) < LW'(hi_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        tmp_next         = tmp_reg;
        is_pop_next      = is_pop_reg;
        m_valid_next     = m_valid_reg;
        m_out_value_next = m_out_value_reg;
        m_out_index_next = m_out_index_reg;
        m_status_next    = m_status_reg;
        m_last_next      = m_last_reg;
        rd_addr          = lo_reg;
        wr_en            = 1'b0;
        wr_addr          = lo_reg;
        wr_data          = rd_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    // Default result: all zero, status ok, last.
                    m_out_value_next = '0;
                    m_out_index_next = '0;
                    m_status_next    = ST_OK;
                    m_last_next      = 1'b1;
                    m_valid_next     = 1'b1;
                    state_next       = S_RESP;
                    case (s_opcode)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_PUSH: begin
                            if (is_full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                wr_en            = 1'b1;
                                wr_addr          = count_reg[IDXW-1:0];
                                wr_data          = s_push_value;
                                count_next       = count_reg + CNTW'(1);
                                m_out_index_next = INDEX_W'(count_reg);
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (is_empty) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                is_pop_next  = (s_opcode == OP_POP);
                                lo_next      = count_m1[IDXW-1:0];
                                rd_addr      = count_m1[IDXW-1:0];
                                state_next   = S_POP;
                            end
                        end
                        OP_DUMP: begin
                            if (is_empty) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                lo_next      = '0;
                                rd_addr      = '0;
                                state_next   = S_DUMP;
                            end
                        end
                        OP_REVERSE: begin
                            if (count_reg > CNTW'(1)) begin
                                m_valid_next = 1'b0;
                                lo_next      = '0;
                                hi_next      = count_m1[IDXW-1:0];
                                rd_addr      = '0;
                                state_next   = S_REV_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                m_out_value_next = rd_data_reg;
                m_out_index_next = INDEX_W'(lo_reg);
                m_valid_next     = 1'b1;
                if (is_pop_reg) begin
                    count_next = CNTW'(lo_reg);
                end
                state_next = S_RESP;
            end
            S_DUMP: begin
                m_out_value_next = rd_data_reg;
                m_out_index_next = INDEX_W'(lo_reg);
                m_status_next    = ST_OK;
                m_last_next      = dump_last;
                m_valid_next     = 1'b1;
                state_next       = S_RESP;
            end
            S_REV_A: begin
                tmp_next   = rd_data_reg;
                rd_addr    = hi_reg;
                state_next = S_REV_B;
            end
            S_REV_B: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = rd_data_reg;
                state_next = S_REV_C;
            end
            S_REV_C: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                lo_next = lo_reg + IDXW'(1);
                hi_next = hi_reg - IDXW'(1);
                rd_addr = lo_reg + IDXW'(1);
                if (rev_more) begin
                    state_next = S_REV_A;
                end else begin
                    m_valid_next = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        // Only a dump leaves a result unmarked: fetch the next entry.
                        lo_next    = lo_reg + IDXW'(1);
                        rd_addr    = lo_reg + IDXW'(1);
                        state_next = S_DUMP;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        tmp_reg         <= tmp_next;
        is_pop_reg      <= is_pop_next;
        m_out_value_reg <= m_out_value_next;
        m_out_index_reg <= m_out_index_next;
        m_status_reg    <= m_status_next;
        m_last_reg      <= m_last_next;
    end

    `BSE_ASSERT_IMPLY(a_ready_result_excl, aclk, aresetn, s_ready, !m_valid)
    `BSE_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNTW'(DEPTH))
    `BSE_ASSERT_NEXT(a_push_grows, aclk, aresetn,
        s_fire && (s_opcode == OP_PUSH) && !is_full,
        count_reg == $past(count_reg) + CNTW'(1))
    `BSE_ASSERT_IMPLY(a_unmarked_is_ok, aclk, aresetn,
        m_valid && !m_last, m_status == ST_OK)

endmodule

// ===== bench/tb_bounded_stack_engine.sv =====
// Self-checking testbench for the bounded stack engine.
`timescale 1ns / 1ps

module tb_bounded_stack_engine
    import bse_pkg::*;
();

    localparam int STACK_DEPTH = 32;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;

    // Opcodes that the block treats as no-ops.
    localparam opcode_t OP_SPARE_6 = 3'd6;
    localparam opcode_t OP_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic        [INDEX_W-1:0] index;
        status_t                   status;
        logic                      last;
    } stack_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    opcode_t                   s_opcode = OP_CLEAR;
    logic signed [VALUE_W-1:0] s_push_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_out_value;
    logic        [INDEX_W-1:0] m_out_index;
    status_t                   m_status;
    logic                      m_last;

    // Shadow copy of the stack and the results it is still owed.
    logic signed [VALUE_W-1:0] stack_words [STACK_DEPTH];
    int                        depth_used = 0;
    stack_result_t             pending_results [$];

    int errors = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    bounded_stack_engine #(
        .DEPTH(STACK_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_push_value(s_push_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_value(m_out_value),
        .m_out_index(m_out_index),
        .m_status(m_status),
        .m_last(m_last)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        stack_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: m_out_value %0d, m_status %0d", m_out_value, m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_out_value !== want.value) begin
                    $error("m_out_value: expected %0d, got %0d", want.value, m_out_value);
                    errors++;
                end
                if (m_out_index !== want.index) begin
                    $error("m_out_index: expected %0d, got %0d", want.index, m_out_index);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("m_last: expected %0d, got %0d", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    function automatic void predict_stack_op(opcode_t op, logic signed [VALUE_W-1:0] word);
        stack_result_t res;
        int n_out;
        int lo;
        int hi;
        logic signed [VALUE_W-1:0] tmp;
        res.value = '0;
        res.index = '0;
        res.status = ST_OK;
        res.last = 1'b1;
        case (op)
            OP_CLEAR: depth_used = 0;
            OP_PUSH: begin
                if (depth_used >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_words[depth_used] = word;
                    res.index = INDEX_W'(depth_used);
                    depth_used++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (depth_used == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = stack_words[depth_used - 1];
                    res.index = INDEX_W'(depth_used - 1);
                    if (op == OP_POP)
                        depth_used--;
                end
            end
            OP_DUMP: begin
                if (depth_used == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    n_out = (depth_used > MAX_RESULTS) ? MAX_RESULTS : depth_used;
                    for (int i = 0; i < n_out; i++) begin
                        res.value = stack_words[i];
                        res.index = INDEX_W'(i);
                        res.last = (i == n_out - 1);
                        pending_results.push_back(res);
                    end
                    return;
                end
            end
            OP_REVERSE: begin
                lo = 0;
                hi = depth_used;
                while (hi > lo + 1) begin
                    tmp = stack_words[lo];
                    stack_words[lo] = stack_words[hi - 1];
                    stack_words[hi - 1] = tmp;
                    lo++;
                    hi--;
                end
            end
            default: ;
        endcase
        pending_results.push_back(res);
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly pushes and pops so that the stack fills and drains over a run.
    function automatic opcode_t random_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) return OP_PUSH;
        if (pick < 65) return OP_POP;
        if (pick < 75) return OP_PEEK;
        if (pick < 83) return OP_DUMP;
        if (pick < 91) return OP_REVERSE;
        if (pick < 96) return OP_CLEAR;
        return $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
    endfunction

    // Called at the edge of the previous acceptance, where s_valid is still high:
    // it is either kept high for this request or lowered for an idle gap.
    task automatic send_request(opcode_t op, logic signed [VALUE_W-1:0] word);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        predict_stack_op(op, word);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_push_value <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_pending();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_request(OP_POP, 32'h1111_1111);
        send_request(OP_PEEK, 32'h0);
        send_request(OP_DUMP, 32'h0);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PEEK, 32'hAAAA_AAAA);
        send_request(OP_DUMP, 32'h0);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_DUMP, 32'h0);
        send_request(OP_POP, 32'h0);
        // An odd count leaves the middle entry where it is.
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_DUMP, 32'h0);
        send_request(OP_SPARE_6, 32'hFFFF_FFFF);
        send_request(OP_SPARE_7, 32'h5555_5555);
        send_request(OP_CLEAR, 32'hFFFF_FFFF);
        send_request(OP_POP, 32'h0);
        send_request(OP_DUMP, 32'h0);
        send_request(OP_PUSH, 32'h1234_5678);
        send_request(OP_POP, 32'h0);
        send_request(OP_POP, 32'h0);
        drain_pending();
    endtask

    task automatic test_fill_to_full();
        idle_pct = 10;
        stall_pct = 10;
        send_request(OP_CLEAR, 32'h0);
        repeat (STACK_DEPTH) send_request(OP_PUSH, random_word());
        repeat (2) send_request(OP_PUSH, random_word());
        send_request(OP_PEEK, 32'h0);
        send_request(OP_DUMP, 32'h0);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_DUMP, 32'h0);
        repeat (3) send_request(OP_POP, 32'h0);
        send_request(OP_PUSH, random_word());
        send_request(OP_DUMP, 32'h0);
        send_request(OP_CLEAR, 32'h0);
        drain_pending();
    endtask

    // The result side stops for a long stretch while requests keep coming.
    task automatic test_output_hold_off();
        idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (16) send_request(random_op(), random_word());
        drain_pending();
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, int n_items);
        idle_pct = send_pct;
        stall_pct = recv_pct;
        repeat (n_items) send_request(random_op(), random_word());
        drain_pending();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_fill_to_full();
        test_random_phase(0, 0, 22);
        test_random_phase(67, 0, 22);
        test_output_hold_off();
        test_random_phase(0, 67, 22);
        test_random_phase(28, 28, 22);
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/bse_pkg.sv
src/bounded_stack_engine.sv
bench/tb_bounded_stack_engine.sv
